>>> src/tgd_pkg.sv
// Shared types and constants for the touch gesture detector.
// Holds the gesture codes, register indexes, reset values and state records.
// No dependencies; used by tgd_eval and touch_gesture_detector_core.
`default_nettype none

package tgd_pkg;

	localparam int unsigned READ_W  = 16;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 2;

	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_SINGLE = 2'd1,
		GEST_DOUBLE = 2'd2,
		GEST_HOLD   = 2'd3
	} gesture_t;

	localparam logic [IDX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
	localparam logic [IDX_W-1:0] REG_DOUBLE_GAP = 2'd2;
	localparam logic [IDX_W-1:0] REG_HOLD_TIME  = 2'd3;

	localparam logic [CFG_W-1:0]   THRESHOLD_RST  = 16'd65;
	localparam logic [CFG_W-1:0]   DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0]   DOUBLE_GAP_RST = 16'd250;
	localparam logic [CFG_W-1:0]   HOLD_TIME_RST  = 16'd1000;
	localparam logic [STAMP_W-1:0] STAMP_RST      = '1;

	typedef struct packed {
		logic [CFG_W-1:0] touch_threshold;
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] double_tap_gap_ms;
		logic [CFG_W-1:0] hold_time_ms;
	} det_cfg_t;

	typedef struct packed {
		logic               touched_before;
		logic               tap_pending;
		logic               double_on_release;
		logic               hold_active;
		logic [STAMP_W-1:0] press_stamp;
		logic [STAMP_W-1:0] release_stamp;
	} det_state_t;

endpackage

`default_nettype wire

>>> src/touch_gesture_detector_core.sv
// Touch gesture detector top level: stream ports, configuration registers,
// input register, detector state and result register. Uses tgd_pkg, tgd_eval.
//
// Usage:
//   Each input transfer on s_axis carries one poll: a raw capacitive reading
//   and a millisecond timestamp. Each poll yields exactly one output transfer
//   on m_axis carrying the gesture code (none, single tap, double tap, holding).
//   Configuration registers are written via cfg_we/cfg_index/cfg_data, one
//   register per cycle; only with no poll in flight, which the user must ensure.
// Timing:
//   A poll in the input register is evaluated combinationally and moves to
//   the result register (driving m_axis) unless the result is stalled. One
//   poll per cycle is sustained while m_axis_tready is high; the path between
//   the two registers holds two 32-bit subtractions and a few compares.
// Reset:
//   arst_n clears both valid flags and returns the detector state and the
//   configuration registers to their defaults (threshold 65, debounce 20 ms,
//   double-tap gap 250 ms, hold time 1000 ms; stamps all ones).
// Stall:
//   While m_axis_tready is low the result is held; one further poll is taken
//   into the input register, then s_axis_tready drops until the result moves.
`default_nettype none

module touch_gesture_detector_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [47:0]                  s_axis_tdata,  // [15:0] touch_reading, [47:16] now_ms
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [7:0]                   m_axis_tdata,  // [1:0] gesture, [7:2] zero
	input  wire                          cfg_we,
	input  wire  [tgd_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [tgd_pkg::CFG_W-1:0]    cfg_data
);

	tgd_pkg::det_cfg_t   cfg_q;
	tgd_pkg::det_state_t st_q;
	tgd_pkg::det_state_t st_next;
	tgd_pkg::gesture_t   gesture;
	tgd_pkg::gesture_t   gesture_q;

	logic                        valid_s1;
	logic [tgd_pkg::READ_W-1:0]  reading_s1;
	logic [tgd_pkg::STAMP_W-1:0] now_s1;
	logic                        out_valid_q;
	logic                        advance;

	// advance the input register into the result register when there is room
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, gesture_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold   <= tgd_pkg::THRESHOLD_RST;
			cfg_q.debounce_ms       <= tgd_pkg::DEBOUNCE_RST;
			cfg_q.double_tap_gap_ms <= tgd_pkg::DOUBLE_GAP_RST;
			cfg_q.hold_time_ms      <= tgd_pkg::HOLD_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgd_pkg::REG_THRESHOLD:  cfg_q.touch_threshold   <= cfg_data;
				tgd_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms       <= cfg_data;
				tgd_pkg::REG_DOUBLE_GAP: cfg_q.double_tap_gap_ms <= cfg_data;
				tgd_pkg::REG_HOLD_TIME:  cfg_q.hold_time_ms      <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			reading_s1 <= s_axis_tdata[15:0];
			now_s1     <= s_axis_tdata[47:16];
		end
	end

	tgd_eval u_eval (
		.cfg     (cfg_q),
		.st      (st_q),
		.reading (reading_s1),
		.now_ms  (now_s1),
		.st_next (st_next),
		.gesture (gesture)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.touched_before    <= 1'b0;
			st_q.tap_pending       <= 1'b0;
			st_q.double_on_release <= 1'b0;
			st_q.hold_active       <= 1'b0;
			st_q.press_stamp       <= tgd_pkg::STAMP_RST;
			st_q.release_stamp     <= tgd_pkg::STAMP_RST;
			out_valid_q            <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			gesture_q <= gesture;
		end
	end

`ifndef SYNTHESIS
	// holding, a pending tap and an armed double tap exclude one another
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({st_q.hold_active, st_q.tap_pending, st_q.double_on_release}))
		else $error("gesture flags overlap");

	// a holding result leaves the hold flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (gesture_q == tgd_pkg::GEST_HOLD)) |-> st_q.hold_active)
		else $error("holding reported without hold flag");

	// a double tap result disarms the double-tap flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (gesture_q == tgd_pkg::GEST_DOUBLE)) |-> !st_q.double_on_release)
		else $error("double tap reported while still armed");

	// state moves only when a poll is evaluated
	assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(st_q))
		else $error("detector state changed without a poll");
`endif

endmodule

`default_nettype wire

>>> src/tgd_eval.sv
// Per-poll gesture evaluation: next detector state and the event for one poll.
// Purely combinational; uses tgd_pkg for the state, configuration and codes.
`default_nettype none

module tgd_eval (
	input  wire tgd_pkg::det_cfg_t            cfg,
	input  wire tgd_pkg::det_state_t          st,
	input  wire [tgd_pkg::READ_W-1:0]         reading,
	input  wire [tgd_pkg::STAMP_W-1:0]        now_ms,
	output tgd_pkg::det_state_t               st_next,
	output tgd_pkg::gesture_t                 gesture
);

	logic                        touched;
	logic [tgd_pkg::STAMP_W-1:0] since_release;
	logic [tgd_pkg::STAMP_W-1:0] since_press;
	logic [tgd_pkg::STAMP_W-1:0] release_after;
	logic [tgd_pkg::STAMP_W-1:0] press_after;
	logic [tgd_pkg::STAMP_W-1:0] deb_ext;
	logic [tgd_pkg::STAMP_W-1:0] gap_ext;
	logic [tgd_pkg::STAMP_W-1:0] hold_ext;
	logic                        press_edge;
	logic                        release_edge;
	logic                        hold_window;

	always_comb begin
		touched  = reading <= cfg.touch_threshold;
		deb_ext  = {{(tgd_pkg::STAMP_W-tgd_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
		gap_ext  = {{(tgd_pkg::STAMP_W-tgd_pkg::CFG_W){1'b0}}, cfg.double_tap_gap_ms};
		hold_ext = {{(tgd_pkg::STAMP_W-tgd_pkg::CFG_W){1'b0}}, cfg.hold_time_ms};

		// elapsed times wrap modulo 2^32
		since_release = now_ms - st.release_stamp;
		since_press   = now_ms - st.press_stamp;

		press_edge   = touched && !st.touched_before && (since_release > deb_ext);
		release_edge = !touched && st.touched_before && (since_press > deb_ext);

		// a fresh edge restamps to now, so its elapsed time drops to zero
		release_after = release_edge ? '0 : since_release;
		press_after   = press_edge ? '0 : since_press;

		// keep testing hold through short dropouts inside the debounce window
		hold_window = touched || (since_press <= deb_ext);

		st_next = st;
		gesture = tgd_pkg::GEST_NONE;
		st_next.touched_before = touched;

		if (press_edge) begin
			st_next.press_stamp = now_ms;
			if ((since_release < gap_ext) && !st.double_on_release && st.tap_pending) begin
				st_next.double_on_release = 1'b1;
				st_next.tap_pending       = 1'b0;
			end else begin
				st_next.double_on_release = 1'b0;
			end
		end else if (release_edge) begin
			st_next.release_stamp = now_ms;
			if (st.hold_active) begin
				st_next.hold_active = 1'b0;
			end else if (!st.double_on_release) begin
				st_next.tap_pending = 1'b1;
			end else begin
				gesture                   = tgd_pkg::GEST_DOUBLE;
				st_next.double_on_release = 1'b0;
			end
		end

		if (!touched && (release_after >= gap_ext) && st_next.tap_pending) begin
			gesture             = tgd_pkg::GEST_SINGLE;
			st_next.tap_pending = 1'b0;
		end

		if (hold_window && (press_after >= hold_ext)) begin
			gesture = tgd_pkg::GEST_HOLD;
			if (!st_next.hold_active) begin
				st_next.double_on_release = 1'b0;
				st_next.tap_pending       = 1'b0;
				st_next.hold_active       = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
